FILE: src/lspf_pkg.sv
// lspf_pkg: widths, codes, command types and the solve program of the plane fit
// used by every module of the block; no dependencies
package lspf_pkg;

   localparam int PT_W       = 24;
   localparam int PSUM_W     = 58;
   localparam int LSUM_W     = 34;
   localparam int CNT_W      = 11;
   localparam int MAX_POINTS = 1024;
   localparam int FRAC_W     = 12;

   localparam int OPA_W      = 128;
   localparam int OPB_W      = 64;
   localparam int ACC_W      = 192;
   localparam int DIGIT_W    = 8;
   localparam int MUL_STEPS  = OPB_W / DIGIT_W;
   localparam int DIV_W      = 200;
   localparam int QUO_W      = 24;
   localparam int DIV_STEPS  = QUO_W + 1;
   localparam int PROG_LEN   = 24;
   localparam int STEP_W     = 5;
   localparam int CYC_W      = 5;
   localparam int SEL_W      = 4;
   localparam int COEF_W     = 2;
   localparam int NCOF       = 6;
   localparam int NNUM       = 3;

   localparam logic [QUO_W-1:0] QLIM_POS = 24'h7FFFFF;
   localparam logic [QUO_W-1:0] QLIM_NEG = 24'h800000;

   // operand selects: sums, then cofactors
   localparam logic [SEL_W-1:0] OP_XX  = 4'd0;
   localparam logic [SEL_W-1:0] OP_XY  = 4'd1;
   localparam logic [SEL_W-1:0] OP_YY  = 4'd2;
   localparam logic [SEL_W-1:0] OP_XZ  = 4'd3;
   localparam logic [SEL_W-1:0] OP_YZ  = 4'd4;
   localparam logic [SEL_W-1:0] OP_X   = 4'd5;
   localparam logic [SEL_W-1:0] OP_Y   = 4'd6;
   localparam logic [SEL_W-1:0] OP_Z   = 4'd7;
   localparam logic [SEL_W-1:0] OP_N   = 4'd8;
   localparam logic [SEL_W-1:0] OP_C00 = 4'd9;
   localparam logic [SEL_W-1:0] OP_C01 = 4'd10;
   localparam logic [SEL_W-1:0] OP_C02 = 4'd11;
   localparam logic [SEL_W-1:0] OP_C11 = 4'd12;
   localparam logic [SEL_W-1:0] OP_C12 = 4'd13;
   localparam logic [SEL_W-1:0] OP_C22 = 4'd14;

   // store targets
   localparam logic [SEL_W-1:0] DST_C00 = 4'd0;
   localparam logic [SEL_W-1:0] DST_C01 = 4'd1;
   localparam logic [SEL_W-1:0] DST_C02 = 4'd2;
   localparam logic [SEL_W-1:0] DST_C11 = 4'd3;
   localparam logic [SEL_W-1:0] DST_C12 = 4'd4;
   localparam logic [SEL_W-1:0] DST_C22 = 4'd5;
   localparam logic [SEL_W-1:0] DST_D   = 4'd6;
   localparam logic [SEL_W-1:0] DST_DA  = 4'd7;
   localparam logic [SEL_W-1:0] DST_DB  = 4'd8;
   localparam logic [SEL_W-1:0] DST_DC  = 4'd9;

   localparam logic [COEF_W-1:0] COEF_A = 2'd0;
   localparam logic [COEF_W-1:0] COEF_B = 2'd1;
   localparam logic [COEF_W-1:0] COEF_C = 2'd2;

   typedef struct packed {
      logic [SEL_W-1:0] a_sel;
      logic [SEL_W-1:0] b_sel;
      logic             clr;
      logic             neg;
      logic             store;
      logic [SEL_W-1:0] dst;
   } step_type;

   typedef struct packed {
      logic              pt_en;
      logic              mul_load;
      logic              mul_step;
      logic              acc_en;
      step_type          step;
      logic              clear_sums;
      logic              div_load;
      logic              div_first;
      logic              div_step;
      logic              div_store;
      logic [COEF_W-1:0] coef;
      logic              fail_set;
      logic              ok_set;
   } ctrl_cmd_type;

   typedef struct packed {
      logic det_zero;
   } dp_status_type;

   function automatic step_type mk(input logic [SEL_W-1:0] a, input logic [SEL_W-1:0] b,
                                   input logic c, input logic n, input logic s,
                                   input logic [SEL_W-1:0] d);
      step_type r;
      r.a_sel = a;
      r.b_sel = b;
      r.clr   = c;
      r.neg   = n;
      r.store = s;
      r.dst   = d;
      return r;
   endfunction

   // cofactors of the symmetric normal matrix, then the four determinants
   function automatic step_type prog_step(input logic [STEP_W-1:0] idx);
      step_type r;
      r = mk(OP_XX, OP_XX, 1'b0, 1'b0, 1'b0, DST_C00);
      unique case (idx)
         5'd0:  r = mk(OP_YY,  OP_N,  1'b1, 1'b0, 1'b0, DST_C00);
         5'd1:  r = mk(OP_Y,   OP_Y,  1'b0, 1'b1, 1'b1, DST_C00);
         5'd2:  r = mk(OP_X,   OP_Y,  1'b1, 1'b0, 1'b0, DST_C01);
         5'd3:  r = mk(OP_XY,  OP_N,  1'b0, 1'b1, 1'b1, DST_C01);
         5'd4:  r = mk(OP_XY,  OP_Y,  1'b1, 1'b0, 1'b0, DST_C02);
         5'd5:  r = mk(OP_YY,  OP_X,  1'b0, 1'b1, 1'b1, DST_C02);
         5'd6:  r = mk(OP_XX,  OP_N,  1'b1, 1'b0, 1'b0, DST_C11);
         5'd7:  r = mk(OP_X,   OP_X,  1'b0, 1'b1, 1'b1, DST_C11);
         5'd8:  r = mk(OP_XY,  OP_X,  1'b1, 1'b0, 1'b0, DST_C12);
         5'd9:  r = mk(OP_XX,  OP_Y,  1'b0, 1'b1, 1'b1, DST_C12);
         5'd10: r = mk(OP_XX,  OP_YY, 1'b1, 1'b0, 1'b0, DST_C22);
         5'd11: r = mk(OP_XY,  OP_XY, 1'b0, 1'b1, 1'b1, DST_C22);
         5'd12: r = mk(OP_C00, OP_XX, 1'b1, 1'b0, 1'b0, DST_D);
         5'd13: r = mk(OP_C01, OP_XY, 1'b0, 1'b0, 1'b0, DST_D);
         5'd14: r = mk(OP_C02, OP_X,  1'b0, 1'b0, 1'b1, DST_D);
         5'd15: r = mk(OP_C00, OP_XZ, 1'b1, 1'b0, 1'b0, DST_DA);
         5'd16: r = mk(OP_C01, OP_YZ, 1'b0, 1'b0, 1'b0, DST_DA);
         5'd17: r = mk(OP_C02, OP_Z,  1'b0, 1'b0, 1'b1, DST_DA);
         5'd18: r = mk(OP_C01, OP_XZ, 1'b1, 1'b0, 1'b0, DST_DB);
         5'd19: r = mk(OP_C11, OP_YZ, 1'b0, 1'b0, 1'b0, DST_DB);
         5'd20: r = mk(OP_C12, OP_Z,  1'b0, 1'b0, 1'b1, DST_DB);
         5'd21: r = mk(OP_C02, OP_XZ, 1'b1, 1'b0, 1'b0, DST_DC);
         5'd22: r = mk(OP_C12, OP_YZ, 1'b0, 1'b0, 1'b0, DST_DC);
         5'd23: r = mk(OP_C22, OP_Z,  1'b0, 1'b0, 1'b1, DST_DC);
         default: r = mk(OP_XX, OP_XX, 1'b0, 1'b0, 1'b0, DST_C00);
      endcase
      return r;
   endfunction

endpackage

FILE: src/lspf_ctrl.sv
// lspf_ctrl: sequencer of the plane fit, drives the datapath commands
// depends on lspf_pkg
module lspf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_point,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  lspf_pkg::dp_status_type status,
   output lspf_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_ACC   = 4'd3;
   localparam logic [3:0] S_CHK   = 4'd4;
   localparam logic [3:0] S_DLOAD = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_DFIN  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]                    state_ff, state_in;
   logic [lspf_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [lspf_pkg::CYC_W-1:0]    cnt_ff, cnt_in;
   logic [lspf_pkg::COEF_W-1:0]   coef_ff, coef_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      cnt_in         = cnt_ff;
      coef_in        = coef_ff;
      cmd            = '0;
      cmd.step       = lspf_pkg::prog_step(step_ff);
      cmd.coef       = coef_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.pt_en = 1'b1;
               if (req_last_point) begin
                  step_in  = '0;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            cmd.mul_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == lspf_pkg::CYC_W'(lspf_pkg::MUL_STEPS - 1)) begin
               state_in = S_ACC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            if (step_ff == lspf_pkg::STEP_W'(lspf_pkg::PROG_LEN - 1)) begin
               state_in = S_CHK;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_CHK: begin
            cmd.clear_sums = 1'b1;
            coef_in        = lspf_pkg::COEF_A;
            if (status.det_zero) begin
               cmd.fail_set = 1'b1;
               state_in     = S_OUT;
            end else begin
               state_in = S_DLOAD;
            end
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            if (cnt_ff == lspf_pkg::CYC_W'(lspf_pkg::DIV_STEPS - 1)) begin
               state_in = S_DFIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DFIN: begin
            cmd.div_store = 1'b1;
            if (coef_ff == lspf_pkg::COEF_C) begin
               cmd.ok_set = 1'b1;
               state_in   = S_OUT;
            end else begin
               coef_in  = coef_ff + 1'b1;
               state_in = S_DLOAD;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
         coef_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         coef_ff  <= coef_in;
      end
   end

   a_rsp_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_CHK || $past(state_ff) == S_DFIN))
      else $error("result shown without a finished solve");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff < lspf_pkg::STEP_W'(lspf_pkg::PROG_LEN))
      else $error("program step out of range");

   a_prog_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_last_point) |=>
         (state_ff == S_LOAD && step_ff == '0))
      else $error("solve did not start at the first step");

endmodule

FILE: src/lspf_dp.sv
// lspf_dp: sums, shared sequential multiplier with accumulator, divider, result registers
// depends on lspf_pkg
module lspf_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lspf_pkg::ctrl_cmd_type              cmd,
   output lspf_pkg::dp_status_type             status,
   input  logic signed [lspf_pkg::PT_W-1:0]    req_point_x,
   input  logic signed [lspf_pkg::PT_W-1:0]    req_point_y,
   input  logic signed [lspf_pkg::PT_W-1:0]    req_point_z,
   output logic signed [lspf_pkg::PT_W-1:0]    rsp_slope_x,
   output logic signed [lspf_pkg::PT_W-1:0]    rsp_slope_y,
   output logic signed [lspf_pkg::PT_W-1:0]    rsp_offset_z,
   output logic                                rsp_fit_ok
);

   localparam int PW = lspf_pkg::PSUM_W;
   localparam int LW = lspf_pkg::LSUM_W;
   localparam int AW = lspf_pkg::OPA_W;
   localparam int BW = lspf_pkg::OPB_W;
   localparam int CW = lspf_pkg::ACC_W;
   localparam int DW = lspf_pkg::DIV_W;
   localparam int GW = lspf_pkg::DIGIT_W;
   localparam int QW = lspf_pkg::QUO_W;

   logic signed [PW-1:0] sxx_ff, sxy_ff, syy_ff, sxz_ff, syz_ff;
   logic signed [LW-1:0] sx_ff, sy_ff, sz_ff;
   logic [lspf_pkg::CNT_W-1:0] cnt_ff;
   logic signed [2*lspf_pkg::PT_W-1:0] pxx, pxy, pyy, pxz, pyz;
   logic room;

   assign pxx  = req_point_x * req_point_x;
   assign pxy  = req_point_x * req_point_y;
   assign pyy  = req_point_y * req_point_y;
   assign pxz  = req_point_x * req_point_z;
   assign pyz  = req_point_y * req_point_z;
   assign room = (cnt_ff < lspf_pkg::CNT_W'(lspf_pkg::MAX_POINTS));

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_sums) begin
         sxx_ff <= '0; sxy_ff <= '0; syy_ff <= '0; sxz_ff <= '0; syz_ff <= '0;
         sx_ff  <= '0; sy_ff  <= '0; sz_ff  <= '0; cnt_ff <= '0;
      end else if (cmd.pt_en && room) begin
         sxx_ff <= sxx_ff + PW'(pxx);
         sxy_ff <= sxy_ff + PW'(pxy);
         syy_ff <= syy_ff + PW'(pyy);
         sxz_ff <= sxz_ff + PW'(pxz);
         syz_ff <= syz_ff + PW'(pyz);
         sx_ff  <= sx_ff + LW'(req_point_x);
         sy_ff  <= sy_ff + LW'(req_point_y);
         sz_ff  <= sz_ff + LW'(req_point_z);
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // operand selection
   logic signed [AW-1:0] cof_ff [lspf_pkg::NCOF];
   logic signed [AW-1:0] opa;
   logic signed [BW-1:0] opb;

   always_comb begin
      unique case (cmd.step.a_sel)
         lspf_pkg::OP_XX:  opa = AW'(sxx_ff);
         lspf_pkg::OP_XY:  opa = AW'(sxy_ff);
         lspf_pkg::OP_YY:  opa = AW'(syy_ff);
         lspf_pkg::OP_XZ:  opa = AW'(sxz_ff);
         lspf_pkg::OP_YZ:  opa = AW'(syz_ff);
         lspf_pkg::OP_X:   opa = AW'(sx_ff);
         lspf_pkg::OP_Y:   opa = AW'(sy_ff);
         lspf_pkg::OP_Z:   opa = AW'(sz_ff);
         lspf_pkg::OP_N:   opa = $signed(AW'(cnt_ff));
         lspf_pkg::OP_C00: opa = cof_ff[0];
         lspf_pkg::OP_C01: opa = cof_ff[1];
         lspf_pkg::OP_C02: opa = cof_ff[2];
         lspf_pkg::OP_C11: opa = cof_ff[3];
         lspf_pkg::OP_C12: opa = cof_ff[4];
         lspf_pkg::OP_C22: opa = cof_ff[5];
         default:          opa = '0;
      endcase
      unique case (cmd.step.b_sel)
         lspf_pkg::OP_XX: opb = BW'(sxx_ff);
         lspf_pkg::OP_XY: opb = BW'(sxy_ff);
         lspf_pkg::OP_YY: opb = BW'(syy_ff);
         lspf_pkg::OP_XZ: opb = BW'(sxz_ff);
         lspf_pkg::OP_YZ: opb = BW'(syz_ff);
         lspf_pkg::OP_X:  opb = BW'(sx_ff);
         lspf_pkg::OP_Y:  opb = BW'(sy_ff);
         lspf_pkg::OP_Z:  opb = BW'(sz_ff);
         lspf_pkg::OP_N:  opb = $signed(BW'(cnt_ff));
         default:         opb = '0;
      endcase
   end

   // sign-magnitude multiplier, one digit of b a cycle from the top
   logic [AW-1:0]    maga_ff;
   logic [BW-1:0]    magb_ff;
   logic             psign_ff;
   logic [CW-1:0]    prod_ff, prod_in;
   logic [AW+GW-1:0] part;

   assign part    = maga_ff * magb_ff[BW-1 -: GW];
   assign prod_in = {prod_ff[CW-GW-1:0], {GW{1'b0}}} + CW'(part);

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         maga_ff  <= opa[AW-1] ? AW'(-opa) : AW'(opa);
         magb_ff  <= opb[BW-1] ? BW'(-opb) : BW'(opb);
         psign_ff <= opa[AW-1] ^ opb[BW-1];
         prod_ff  <= '0;
      end else if (cmd.mul_step) begin
         prod_ff <= prod_in;
         magb_ff <= {magb_ff[BW-GW-1:0], {GW{1'b0}}};
      end
   end

   // accumulator and stores
   logic signed [CW-1:0] acc_ff, acc_in, sprod;
   logic signed [CW-1:0] det_ff;
   logic signed [CW-1:0] num_ff [lspf_pkg::NNUM];

   assign sprod  = (psign_ff ^ cmd.step.neg) ? -$signed(prod_ff) : $signed(prod_ff);
   assign acc_in = (cmd.step.clr ? '0 : acc_ff) + sprod;

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
         if (cmd.step.store) begin
            unique case (cmd.step.dst)
               lspf_pkg::DST_C00: cof_ff[0] <= acc_in[AW-1:0];
               lspf_pkg::DST_C01: cof_ff[1] <= acc_in[AW-1:0];
               lspf_pkg::DST_C02: cof_ff[2] <= acc_in[AW-1:0];
               lspf_pkg::DST_C11: cof_ff[3] <= acc_in[AW-1:0];
               lspf_pkg::DST_C12: cof_ff[4] <= acc_in[AW-1:0];
               lspf_pkg::DST_C22: cof_ff[5] <= acc_in[AW-1:0];
               lspf_pkg::DST_D:   det_ff    <= acc_in;
               lspf_pkg::DST_DA:  num_ff[0] <= acc_in;
               lspf_pkg::DST_DB:  num_ff[1] <= acc_in;
               lspf_pkg::DST_DC:  num_ff[2] <= acc_in;
               default: ;
            endcase
         end
      end
   end

   assign status.det_zero = (det_ff == '0);

   // restoring divider for round(num/det), saturating quotient
   logic signed [DW-1:0] num_ext, den_ext;
   logic [DW-1:0]        nmag, dmag;
   logic [DW-1:0]        rem_ff, dv_ff;
   logic [QW-1:0]        q_ff, lim, mag, res;
   logic                 big_ff, neg_ff, ge;

   always_comb begin
      num_ext = DW'(num_ff[cmd.coef]);
      if (cmd.coef != lspf_pkg::COEF_C) begin
         num_ext = num_ext <<< lspf_pkg::FRAC_W;
      end
      den_ext = DW'(det_ff);
      nmag    = num_ext[DW-1] ? DW'(-num_ext) : DW'(num_ext);
      dmag    = den_ext[DW-1] ? DW'(-den_ext) : DW'(den_ext);
   end

   assign ge  = (rem_ff >= dv_ff);
   assign lim = neg_ff ? lspf_pkg::QLIM_NEG : lspf_pkg::QLIM_POS;
   assign mag = (big_ff || q_ff > lim) ? lim : q_ff;
   assign res = neg_ff ? -mag : mag;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= {nmag[DW-2:0], 1'b0} + dmag;
         dv_ff  <= dmag << (QW + 1);
         neg_ff <= num_ext[DW-1] ^ den_ext[DW-1];
         big_ff <= 1'b0;
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         dv_ff <= dv_ff >> 1;
         if (cmd.div_first) begin
            big_ff <= ge;
         end else if (ge) begin
            rem_ff <= rem_ff - dv_ff;
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            q_ff <= {q_ff[QW-2:0], 1'b0};
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.fail_set) begin
         rsp_slope_x  <= '0;
         rsp_slope_y  <= '0;
         rsp_offset_z <= '0;
         rsp_fit_ok   <= 1'b0;
      end else begin
         if (cmd.div_store) begin
            case (cmd.coef)
               lspf_pkg::COEF_A: rsp_slope_x  <= res;
               lspf_pkg::COEF_B: rsp_slope_y  <= res;
               default:          rsp_offset_z <= res;
            endcase
         end
         if (cmd.ok_set) begin
            rsp_fit_ok <= 1'b1;
         end
      end
   end

endmodule

FILE: src/least_squares_plane_fit_top.sv
// least_squares_plane_fit_top: plane fit z = a*x + b*y + c over a point stream
// depends on lspf_pkg, lspf_ctrl, lspf_dp
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   point_x, point_y, point_z, last_point
//   rsp      out        rsp_valid / rsp_stall   slope_x, slope_y, offset_z, fit_ok
//
// a point without last_point is taken in one cycle; points can follow back to back
// the last point starts the solve: 24 products on the shared 8-bit-digit multiplier,
// one determinant check, then 3 divisions unless the determinant is zero
// req_stall stays high from the last point until its result beat is taken
// synchronous reset clears the sums, the count and the sequencer
module least_squares_plane_fit_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [lspf_pkg::PT_W-1:0]  req_point_x,
   input  logic signed [lspf_pkg::PT_W-1:0]  req_point_y,
   input  logic signed [lspf_pkg::PT_W-1:0]  req_point_z,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [lspf_pkg::PT_W-1:0]  rsp_slope_x,
   output logic signed [lspf_pkg::PT_W-1:0]  rsp_slope_y,
   output logic signed [lspf_pkg::PT_W-1:0]  rsp_offset_z,
   output logic                              rsp_fit_ok
);

   lspf_pkg::ctrl_cmd_type  cmd;
   lspf_pkg::dp_status_type status;

   lspf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   lspf_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .rsp_slope_x  (rsp_slope_x),
      .rsp_slope_y  (rsp_slope_y),
      .rsp_offset_z (rsp_offset_z),
      .rsp_fit_ok   (rsp_fit_ok)
   );

endmodule
